// ----- hw/rtl/lfusr_pkg.sv -----
// Package for the LFU slot replacement block: operation codes and the fixed
// widths of the command and configuration fields.
// Depends on nothing; used by the top level lfu_slot_replacement.
package lfusr_pkg;

  // Operation codes carried by operation_i.
  localparam logic OP_RECOMMEND = 1'b0;
  localparam logic OP_READ      = 1'b1;

  // Fixed field widths of the command, result and configuration ports.
  localparam int SLOT_INDEX_W = 5;
  localparam int FILLED_W     = 6;
  localparam int LIMIT_W      = 6;

  // Reset value of the slot limit register.
  localparam logic [LIMIT_W-1:0] LIMIT_RESET = 6'd32;

endpackage

// ----- hw/rtl/lfu_slot_replacement.sv -----
// Top level of the LFU slot replacement block: command sequencer and slot table.
// Depends on lfusr_pkg and lfusr_ram.

// The block holds up to SLOTS slots of id and hit count in one synchronous RAM,
// kept in insertion order, and handles one command at a time: busy_o is high
// from the cycle after start_i is taken until the work is done, and the result
// shows on the result ports for exactly one cycle, marked by done_o, in the
// cycle in which busy_o falls. The receiver cannot stall, so it must take every
// result in that cycle. A recommend of id zero never raises busy_o. Any other
// recommend reads every occupied slot through the RAM read port, one per cycle.
// An eviction of the youngest slot needs no extra state, since the new id
// overwrites it at once; any other eviction moves each slot behind the victim
// down one place in StShift, then places the new id in StPlace. The RAM needs no
// clearing pass: only slots below the fill count are ever read.
module lfu_slot_replacement #(
  parameter int SLOTS      = 32,
  parameter int ID_BITS    = 10,
  parameter int COUNT_BITS = 16
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  // Configuration write port.
  input  logic                                  cfg_we_i,
  input  logic [lfusr_pkg::LIMIT_W-1:0]         cfg_wdata_i,
  // Command transaction.
  input  logic                                  start_i,
  output logic                                  busy_o,
  input  logic                                  operation_i,
  input  logic [ID_BITS-1:0]                    candidate_id_i,
  input  logic [lfusr_pkg::SLOT_INDEX_W-1:0]    slot_index_i,
  // Result transaction.
  output logic                                  done_o,
  output logic                                  was_hit_o,
  output logic                                  was_evicted_o,
  output logic [ID_BITS-1:0]                    evicted_id_o,
  output logic [ID_BITS-1:0]                    read_id_o,
  output logic [COUNT_BITS-1:0]                 read_count_o,
  output logic [lfusr_pkg::FILLED_W-1:0]        filled_slots_o
);

  localparam int AW      = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int FW      = $clog2(SLOTS + 1);
  localparam int CW      = (FW > lfusr_pkg::LIMIT_W) ? FW : lfusr_pkg::LIMIT_W;
  localparam int EW      = ID_BITS + COUNT_BITS;
  localparam int FillOutW = lfusr_pkg::FILLED_W;

  // Sequencer states.
  localparam logic [2:0] StIdle   = 3'd0;
  localparam logic [2:0] StRead   = 3'd1;
  localparam logic [2:0] StScan   = 3'd2;
  localparam logic [2:0] StDecide = 3'd3;
  localparam logic [2:0] StShift  = 3'd4;
  localparam logic [2:0] StPlace  = 3'd5;

  logic [2:0]                       state_q, state_d;
  logic [lfusr_pkg::LIMIT_W-1:0]    limit_q, limit_d;
  logic [FW-1:0]                    fill_q, fill_d;
  logic                             done_q, done_d;
  logic [ID_BITS-1:0]               cand_q, cand_d;
  logic                             rd_ok_q, rd_ok_d;
  logic [AW-1:0]                    chk_q, chk_d;
  logic [AW-1:0]                    ptr_q, ptr_d;
  logic                             hit_q, hit_d;
  logic [AW-1:0]                    hit_idx_q, hit_idx_d;
  logic [COUNT_BITS-1:0]            hit_cnt_q, hit_cnt_d;
  logic [AW-1:0]                    min_idx_q, min_idx_d;
  logic [COUNT_BITS-1:0]            min_cnt_q, min_cnt_d;
  logic [ID_BITS-1:0]               min_id_q, min_id_d;
  logic                             evict_q, evict_d;
  logic [ID_BITS-1:0]               evid_q, evid_d;
  logic [ID_BITS-1:0]               rid_q, rid_d;
  logic [COUNT_BITS-1:0]            rcnt_q, rcnt_d;

  // RAM port signals.
  logic                             ram_we;
  logic [AW-1:0]                    ram_waddr;
  logic [EW-1:0]                    ram_wdata;
  logic                             ram_re;
  logic [AW-1:0]                    ram_raddr;
  logic [EW-1:0]                    ram_rdata;
  logic [ID_BITS-1:0]               rd_id;
  logic [COUNT_BITS-1:0]            rd_cnt;

  // Derived values used by the sequencer.
  logic [CW-1:0]                    limit_ext;
  logic [CW-1:0]                    limit_eff;
  logic [CW-1:0]                    fill_ext;
  logic [CW-1:0]                    pos_ext;
  logic [FW-1:0]                    chk_next;
  logic [FW-1:0]                    last_fw;
  logic [AW-1:0]                    last_idx;
  logic [AW-1:0]                    ptr_inc;
  logic [COUNT_BITS-1:0]            hit_cnt_inc;

  lfusr_ram #(
    .WIDTH (EW),
    .DEPTH (SLOTS)
  ) u_slot_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign rd_id  = ram_rdata[EW-1:COUNT_BITS];
  assign rd_cnt = ram_rdata[COUNT_BITS-1:0];

  // A limit of zero acts as one and a limit above the slot count acts as the slot count.
  assign limit_ext = CW'(limit_q);
  always_comb begin
    if (limit_q == '0) begin
      limit_eff = CW'(1);
    end else if (limit_ext > CW'(SLOTS)) begin
      limit_eff = CW'(SLOTS);
    end else begin
      limit_eff = limit_ext;
    end
  end

  assign fill_ext    = CW'(fill_q);
  assign pos_ext     = CW'(slot_index_i);
  assign chk_next    = FW'(chk_q) + FW'(1);
  assign last_fw     = fill_q - FW'(1);
  assign last_idx    = AW'(last_fw);
  assign ptr_inc     = ptr_q + AW'(1);
  assign hit_cnt_inc = (&hit_cnt_q) ? hit_cnt_q : hit_cnt_q + COUNT_BITS'(1);

  // Command sequencer: read, scan, decide, close up and place.
  always_comb begin
    state_d   = state_q;
    limit_d   = limit_q;
    fill_d    = fill_q;
    done_d    = 1'b0;
    cand_d    = cand_q;
    rd_ok_d   = rd_ok_q;
    chk_d     = chk_q;
    ptr_d     = ptr_q;
    hit_d     = hit_q;
    hit_idx_d = hit_idx_q;
    hit_cnt_d = hit_cnt_q;
    min_idx_d = min_idx_q;
    min_cnt_d = min_cnt_q;
    min_id_d  = min_id_q;
    evict_d   = evict_q;
    evid_d    = evid_q;
    rid_d     = rid_q;
    rcnt_d    = rcnt_q;
    ram_we    = 1'b0;
    ram_waddr = '0;
    ram_wdata = '0;
    ram_re    = 1'b0;
    ram_raddr = '0;

    if (cfg_we_i) begin
      limit_d = cfg_wdata_i;
    end

    case (state_q)
      StIdle: begin
        if (start_i) begin
          cand_d  = candidate_id_i;
          hit_d   = 1'b0;
          evict_d = 1'b0;
          evid_d  = '0;
          rid_d   = '0;
          rcnt_d  = '0;
          chk_d   = '0;
          if (operation_i == lfusr_pkg::OP_READ) begin
            // Positions at or beyond the fill read as empty.
            rd_ok_d   = (pos_ext < fill_ext) && (pos_ext < CW'(SLOTS));
            ram_re    = rd_ok_d;
            ram_raddr = AW'(slot_index_i);
            state_d   = StRead;
          end else if (candidate_id_i == '0) begin
            // Id zero marks an empty slot and changes nothing.
            done_d = 1'b1;
          end else if (fill_q == '0) begin
            state_d = StDecide;
          end else begin
            ram_re    = 1'b1;
            ram_raddr = '0;
            state_d   = StScan;
          end
        end
      end

      StRead: begin
        if (rd_ok_q) begin
          rid_d  = rd_id;
          rcnt_d = rd_cnt;
        end
        done_d  = 1'b1;
        state_d = StIdle;
      end

      StScan: begin
        // Data for slot chk_q arrives; the next slot is requested meanwhile.
        if (!hit_q && (rd_id == cand_q)) begin
          hit_d     = 1'b1;
          hit_idx_d = chk_q;
          hit_cnt_d = rd_cnt;
        end
        if ((chk_q == '0) || (rd_cnt < min_cnt_q)) begin
          min_idx_d = chk_q;
          min_cnt_d = rd_cnt;
          min_id_d  = rd_id;
        end
        if (chk_next == fill_q) begin
          state_d = StDecide;
        end else begin
          ram_re    = 1'b1;
          ram_raddr = AW'(chk_next);
          chk_d     = AW'(chk_next);
        end
      end

      StDecide: begin
        if (hit_q) begin
          ram_we    = 1'b1;
          ram_waddr = hit_idx_q;
          ram_wdata = {cand_q, hit_cnt_inc};
          done_d    = 1'b1;
          state_d   = StIdle;
        end else if (CW'(fill_q) < limit_eff) begin
          ram_we    = 1'b1;
          ram_waddr = AW'(fill_q);
          ram_wdata = {cand_q, COUNT_BITS'(1)};
          fill_d    = fill_q + FW'(1);
          done_d    = 1'b1;
          state_d   = StIdle;
        end else begin
          evict_d = 1'b1;
          evid_d  = min_id_q;
          if (min_idx_q == last_idx) begin
            ram_we    = 1'b1;
            ram_waddr = last_idx;
            ram_wdata = {cand_q, COUNT_BITS'(1)};
            done_d    = 1'b1;
            state_d   = StIdle;
          end else begin
            ram_re    = 1'b1;
            ram_raddr = min_idx_q + AW'(1);
            ptr_d     = min_idx_q;
            state_d   = StShift;
          end
        end
      end

      StShift: begin
        // Slot ptr_q + 1 arrives and moves down to ptr_q.
        ram_we    = 1'b1;
        ram_waddr = ptr_q;
        ram_wdata = ram_rdata;
        ptr_d     = ptr_inc;
        if (ptr_inc == last_idx) begin
          state_d = StPlace;
        end else begin
          ram_re    = 1'b1;
          ram_raddr = ptr_inc + AW'(1);
        end
      end

      StPlace: begin
        ram_we    = 1'b1;
        ram_waddr = last_idx;
        ram_wdata = {cand_q, COUNT_BITS'(1)};
        done_d    = 1'b1;
        state_d   = StIdle;
      end

      default: begin
        state_d = StIdle;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      limit_q <= lfusr_pkg::LIMIT_RESET;
      fill_q  <= '0;
      done_q  <= 1'b0;
      hit_q   <= 1'b0;
      evict_q <= 1'b0;
    end else begin
      state_q <= state_d;
      limit_q <= limit_d;
      fill_q  <= fill_d;
      done_q  <= done_d;
      hit_q   <= hit_d;
      evict_q <= evict_d;
    end
  end

  // Working and result payload registers.
  always_ff @(posedge clk_i) begin
    cand_q    <= cand_d;
    rd_ok_q   <= rd_ok_d;
    chk_q     <= chk_d;
    ptr_q     <= ptr_d;
    hit_idx_q <= hit_idx_d;
    hit_cnt_q <= hit_cnt_d;
    min_idx_q <= min_idx_d;
    min_cnt_q <= min_cnt_d;
    min_id_q  <= min_id_d;
    evid_q    <= evid_d;
    rid_q     <= rid_d;
    rcnt_q    <= rcnt_d;
  end

  assign busy_o         = (state_q != StIdle);
  assign done_o         = done_q;
  assign was_hit_o      = hit_q;
  assign was_evicted_o  = evict_q;
  assign evicted_id_o   = evid_q;
  assign read_id_o      = rid_q;
  assign read_count_o   = rcnt_q;
  assign filled_slots_o = FillOutW'(fill_q);

endmodule

// ----- hw/rtl/lfusr_ram.sv -----
// Generic single-write, single-read synchronous RAM with a registered read.
// Depends on nothing; instanced by lfu_slot_replacement for the slot table.
module lfusr_ram #(
  parameter int WIDTH = 26,
  parameter int DEPTH = 32,
  localparam int AddrW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Read port: the data is registered and shows in the cycle after the read.
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- tb/tb_top.sv -----
// Self-checking testbench for lfu_slot_replacement: directed, back-to-back and random commands.
// Depends on lfusr_pkg and the lfu_slot_replacement RTL; it reads no files.
module tb_top;

  localparam int SLOTS          = 32;
  localparam int ID_BITS        = 10;
  localparam int COUNT_BITS     = 16;
  localparam int IDX_W          = lfusr_pkg::SLOT_INDEX_W;
  localparam int FILL_W         = lfusr_pkg::FILLED_W;
  localparam int WATCHDOG_LIMIT = 3000;
  localparam int ITEMS_PER_MODE = 108;
  localparam int HIT_RUN        = 60;

  typedef struct packed {
    logic                    op;
    logic [ID_BITS-1:0]      id;
    logic [IDX_W-1:0]        idx;
  } slot_cmd_t;

  typedef struct packed {
    logic                  hit;
    logic                  evicted;
    logic [ID_BITS-1:0]    evicted_id;
    logic [ID_BITS-1:0]    read_id;
    logic [COUNT_BITS-1:0] read_count;
    logic [FILL_W-1:0]     filled;
  } slot_result_t;

  logic                             clk_i = 1'b0;
  logic                             rst_ni = 1'b0;
  logic                             cfg_we_i = 1'b0;
  logic [lfusr_pkg::LIMIT_W-1:0]    cfg_wdata_i = '0;
  logic                             start_i = 1'b0;
  logic                             operation_i = lfusr_pkg::OP_RECOMMEND;
  logic [ID_BITS-1:0]               candidate_id_i = '0;
  logic [IDX_W-1:0]                 slot_index_i = '0;
  logic                             busy_o;
  logic                             done_o;
  logic                             was_hit_o;
  logic                             was_evicted_o;
  logic [ID_BITS-1:0]               evicted_id_o;
  logic [ID_BITS-1:0]               read_id_o;
  logic [COUNT_BITS-1:0]            read_count_o;
  logic [FILL_W-1:0]                filled_slots_o;

  // Commands waiting to be sent and results waiting to arrive.
  slot_cmd_t    cmd_queue[$];
  slot_result_t pending_results[$];

  // Shadow copy of the slot table and the limit register.
  logic [ID_BITS-1:0]            shadow_ids[SLOTS];
  logic [COUNT_BITS-1:0]         shadow_counts[SLOTS];
  int                            shadow_fill = 0;
  logic [lfusr_pkg::LIMIT_W-1:0] shadow_limit = lfusr_pkg::LIMIT_RESET;

  int idle_pct = 34;
  int mismatch_cnt = 0;
  int quiet_cycles = 0;

  lfu_slot_replacement #(
    .SLOTS      (SLOTS),
    .ID_BITS    (ID_BITS),
    .COUNT_BITS (COUNT_BITS)
  ) DUT (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .start_i        (start_i),
    .busy_o         (busy_o),
    .operation_i    (operation_i),
    .candidate_id_i (candidate_id_i),
    .slot_index_i   (slot_index_i),
    .done_o         (done_o),
    .was_hit_o      (was_hit_o),
    .was_evicted_o  (was_evicted_o),
    .evicted_id_o   (evicted_id_o),
    .read_id_o      (read_id_o),
    .read_count_o   (read_count_o),
    .filled_slots_o (filled_slots_o)
  );

  always #1 clk_i = ~clk_i;

  // Apply one command to the shadow table and return the result it must produce.
  function automatic slot_result_t lfu_table_update(input slot_cmd_t c);
    slot_result_t          r;
    int                    lim;
    int                    victim;
    int                    last;
    int                    i;
    bit                    found;
    logic [COUNT_BITS-1:0] least;
    r = '0;
    found = 1'b0;
    if (c.op == lfusr_pkg::OP_READ) begin
      if (int'(c.idx) < shadow_fill) begin
        r.read_id    = shadow_ids[c.idx];
        r.read_count = shadow_counts[c.idx];
      end
    end else if (c.id != '0) begin
      for (i = 0; i < shadow_fill; i++) begin
        if (!found && shadow_ids[i] == c.id) begin
          found = 1'b1;
          if (shadow_counts[i] != '1) shadow_counts[i]++;
        end
      end
      lim = int'(shadow_limit);
      if (lim < 1) lim = 1;
      if (lim > SLOTS) lim = SLOTS;
      if (found) begin
        r.hit = 1'b1;
      end else if (shadow_fill < lim) begin
        shadow_ids[shadow_fill]    = c.id;
        shadow_counts[shadow_fill] = COUNT_BITS'(1);
        shadow_fill++;
      end else if (shadow_fill > 0) begin
        // Least count wins; a strict compare keeps the oldest on ties.
        last   = shadow_fill - 1;
        victim = 0;
        least  = shadow_counts[0];
        for (i = 1; i <= last; i++) begin
          if (shadow_counts[i] < least) begin
            least  = shadow_counts[i];
            victim = i;
          end
        end
        r.evicted    = 1'b1;
        r.evicted_id = shadow_ids[victim];
        for (i = victim; i < last; i++) begin
          shadow_ids[i]    = shadow_ids[i + 1];
          shadow_counts[i] = shadow_counts[i + 1];
        end
        shadow_ids[last]    = c.id;
        shadow_counts[last] = COUNT_BITS'(1);
      end
    end
    r.filled = FILL_W'(shadow_fill);
    return r;
  endfunction

  function automatic slot_cmd_t make_cmd(input logic op, input int id, input int idx);
    slot_cmd_t c;
    c.op  = op;
    c.id  = ID_BITS'(id);
    c.idx = IDX_W'(idx);
    return c;
  endfunction

  // Random command; most ids come from a small pool so that hits and evictions mix.
  function automatic slot_cmd_t random_cmd(input int pool);
    slot_cmd_t c;
    int        pick;
    pick  = $urandom_range(99);
    c.op  = (pick < 28) ? lfusr_pkg::OP_READ : lfusr_pkg::OP_RECOMMEND;
    if ($urandom_range(1) != 0) begin
      c.idx = IDX_W'($urandom_range(SLOTS - 1));
    end else begin
      c.idx = IDX_W'($urandom_range(pool > 31 ? 31 : pool));
    end
    if (pick >= 28 && pick < 33) begin
      c.id = '0;
    end else if (pick < 43) begin
      c.id = ID_BITS'($urandom_range(1023, 1));
    end else begin
      c.id = ID_BITS'($urandom_range(pool, 1));
    end
    return c;
  endfunction

  task automatic report_mismatch(input string msg);
    mismatch_cnt++;
    $display("%0t mismatch: %s", $time, msg);
  endtask

  // Wait until the command queue is empty and every result has come back.
  task automatic drain();
    while (cmd_queue.size() != 0 || start_i || pending_results.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (4) @(posedge clk_i);
  endtask

  // Write the limit register while the block is idle.
  task automatic write_limit(input logic [lfusr_pkg::LIMIT_W-1:0] value);
    drain();
    @(posedge clk_i);
    cfg_we_i     <= 1'b1;
    cfg_wdata_i  <= value;
    shadow_limit = value;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic random_phase(input logic [lfusr_pkg::LIMIT_W-1:0] value);
    int lim;
    int n;
    write_limit(value);
    lim = (value == 0) ? 1 : (value > SLOTS) ? SLOTS : int'(value);
    for (n = 0; n < ITEMS_PER_MODE; n++) cmd_queue.push_back(random_cmd(lim * 3 / 2 + 2));
  endtask

  // Driver: a command transaction is taken when start is high and busy is low.
  always @(posedge clk_i) begin : drive_cmd
    bit go;
    if (rst_ni) begin
      if (start_i && !busy_o) pending_results.push_back(lfu_table_update(cmd_queue.pop_front()));
      go = (cmd_queue.size() != 0) && ($urandom_range(99) >= idle_pct);
      start_i <= go;
      if (go) begin
        operation_i    <= cmd_queue[0].op;
        candidate_id_i <= cmd_queue[0].id;
        slot_index_i   <= cmd_queue[0].idx;
      end
    end
  end

  // Monitor: every strobed result is checked against the oldest expectation.
  always @(posedge clk_i) begin : check_result
    slot_result_t want;
    if (rst_ni && done_o) begin
      if (pending_results.size() == 0) begin
        report_mismatch("result transaction with none pending");
      end else begin
        want = pending_results.pop_front();
        if (was_hit_o !== want.hit)
          report_mismatch($sformatf("was_hit %0d, expected %0d", was_hit_o, want.hit));
        if (was_evicted_o !== want.evicted)
          report_mismatch($sformatf("was_evicted %0d, expected %0d", was_evicted_o,
                                    want.evicted));
        if (evicted_id_o !== want.evicted_id)
          report_mismatch($sformatf("evicted_id %0d, expected %0d", evicted_id_o,
                                    want.evicted_id));
        if (read_id_o !== want.read_id)
          report_mismatch($sformatf("read_id %0d, expected %0d", read_id_o, want.read_id));
        if (read_count_o !== want.read_count)
          report_mismatch($sformatf("read_count %0d, expected %0d", read_count_o,
                                    want.read_count));
        if (filled_slots_o !== want.filled)
          report_mismatch($sformatf("filled_slots %0d, expected %0d", filled_slots_o,
                                    want.filled));
      end
    end
  end

  // Watchdog: too many cycles without any transaction ends the run.
  always @(posedge clk_i) begin
    if (!rst_ni || (start_i && !busy_o) || done_o) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("tb_top: errors");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Stimulus sequence.
  initial begin
    int n;
    for (n = 0; n < SLOTS; n++) begin
      shadow_ids[n]    = '0;
      shadow_counts[n] = '0;
    end
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Empty table, zero candidate, a first fill and a hit.
    cmd_queue.push_back(make_cmd(lfusr_pkg::OP_READ, 0, 0));
    cmd_queue.push_back(make_cmd(lfusr_pkg::OP_READ, 1023, 31));
    cmd_queue.push_back(make_cmd(lfusr_pkg::OP_RECOMMEND, 0, 0));
    cmd_queue.push_back(make_cmd(lfusr_pkg::OP_RECOMMEND, 1023, 31));
    cmd_queue.push_back(make_cmd(lfusr_pkg::OP_RECOMMEND, 1023, 0));
    drain();

    // A long run of hits on a single slot, with no idling at all.
    idle_pct = 0;
    for (n = 0; n < HIT_RUN; n++) begin
      cmd_queue.push_back(make_cmd(lfusr_pkg::OP_RECOMMEND, 1023, 0));
    end
    cmd_queue.push_back(make_cmd(lfusr_pkg::OP_READ, 0, 0));
    drain();
    idle_pct = 34;

    // More fills, reads inside and beyond the fill, alternating id bits.
    cmd_queue.push_back(make_cmd(lfusr_pkg::OP_RECOMMEND, 0, 31));
    cmd_queue.push_back(make_cmd(lfusr_pkg::OP_RECOMMEND, 1, 0));
    cmd_queue.push_back(make_cmd(lfusr_pkg::OP_RECOMMEND, 341, 0));
    cmd_queue.push_back(make_cmd(lfusr_pkg::OP_RECOMMEND, 682, 0));
    cmd_queue.push_back(make_cmd(lfusr_pkg::OP_RECOMMEND, 512, 0));
    cmd_queue.push_back(make_cmd(lfusr_pkg::OP_RECOMMEND, 1, 0));
    cmd_queue.push_back(make_cmd(lfusr_pkg::OP_READ, 0, 1));
    cmd_queue.push_back(make_cmd(lfusr_pkg::OP_READ, 0, 4));
    cmd_queue.push_back(make_cmd(lfusr_pkg::OP_READ, 0, 5));
    cmd_queue.push_back(make_cmd(lfusr_pkg::OP_READ, 1023, 31));

    // Limit zero acts as one, so the fill is already above it: evict among all.
    write_limit('0);
    cmd_queue.push_back(make_cmd(lfusr_pkg::OP_RECOMMEND, 77, 0));
    cmd_queue.push_back(make_cmd(lfusr_pkg::OP_RECOMMEND, 78, 0));
    cmd_queue.push_back(make_cmd(lfusr_pkg::OP_READ, 0, 4));
    cmd_queue.push_back(make_cmd(lfusr_pkg::OP_RECOMMEND, 0, 0));

    // Random phases over a sweep of limits, lowered and raised around the fill.
    random_phase(6'd0);
    random_phase(6'd7);
    random_phase(6'd2);
    random_phase(6'd32);
    random_phase(6'd63);
    random_phase(6'd12);
    random_phase(6'd1);
    random_phase(6'd32);

    drain();
    repeat (8) @(posedge clk_i);
    if (mismatch_cnt == 0) begin
      $display("tb_top: clean");
    end else begin
      $display("tb_top: errors");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
hw/rtl/lfusr_pkg.sv
hw/rtl/lfusr_ram.sv
hw/rtl/lfu_slot_replacement.sv
tb/tb_top.sv
